// ===== rtl/handle_slot_pool_assert.svh =====
// Assertion macros shared by the handle slot pool RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef HANDLE_SLOT_POOL_ASSERT_SVH
`define HANDLE_SLOT_POOL_ASSERT_SVH
`ifndef SYNTHESIS
// The condition holds at every clock edge outside reset.
`define HSP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// The consequent holds in the same cycle as the antecedent.
`define HSP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define HSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HSP_ASSERT_ALWAYS(lbl, cond, msg)
`define HSP_ASSERT_IMPL(lbl, ante, cons, msg)
`define HSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/hsp_pkg.sv =====
// Package for the handle slot pool: payload structs, operation and status codes, defaults.
// No dependencies.
package hsp_pkg;

	localparam int unsigned MH_W       = 4;
	localparam int unsigned HANDLE_W   = 3;
	localparam int unsigned MAX_SEARCH = (1 << MH_W) - 1;
	localparam int unsigned HANDLE_MAX = 1 << HANDLE_W;

	localparam logic [MH_W-1:0] MAX_HANDLES_RESET = 4'd8;

	localparam logic [2:0] OP_ALLOC  = 3'd0;
	localparam logic [2:0] OP_FREE   = 3'd1;
	localparam logic [2:0] OP_SET    = 3'd2;
	localparam logic [2:0] OP_GET    = 3'd3;
	localparam logic [2:0] OP_COMMIT = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NONE_FREE = 2'd1;
	localparam logic [1:0] ST_BAD_SLOT  = 2'd2;

	localparam logic signed [31:0] DEFAULT_A = 32'sd31;
	localparam logic signed [31:0] DEFAULT_B = 32'sd100;
	localparam logic signed [31:0] DEFAULT_C = 32'sd0;

	typedef struct packed {
		logic [2:0]         op;
		logic [2:0]         handle;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic signed [31:0] value_c;
	} hsp_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [2:0]         slot;
		logic signed [31:0] out_a;
		logic signed [31:0] out_b;
		logic signed [31:0] out_c;
		logic               pending;
		logic [3:0]         used_count;
	} hsp_out_t;

	typedef struct packed {
		logic            found;
		logic [MH_W-1:0] index;
	} hsp_search_t;

endpackage

// ===== rtl/hsp_first_free.sv =====
// Lowest-free-slot priority encoder for the handle slot pool.
// Depends on hsp_pkg.
module hsp_first_free import hsp_pkg::*; #(
	parameter int unsigned SEARCH = 8
) (
	input  logic [SEARCH-1:0] used,
	input  logic [MH_W-1:0]   limit,
	output hsp_search_t       search
);

	// Scanning from the top down leaves the lowest eligible slot in the result.
	always_comb begin
		search = '0;
		for (int i = int'(SEARCH) - 1; i >= 0; i--) begin
			if (!used[i] && (MH_W'(i) < limit)) begin
				search.found = 1'b1;
				search.index = MH_W'(i);
			end
		end
	end

endmodule

// ===== rtl/hsp_core.sv =====
// Slot state and operation logic of the handle slot pool.
// Depends on hsp_pkg, hsp_first_free and handle_slot_pool_assert.svh.
`include "handle_slot_pool_assert.svh"
module hsp_core import hsp_pkg::*; #(
	parameter int unsigned SLOTS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  hsp_in_t         item,
	input  logic [MH_W-1:0] max_handles,
	output hsp_out_t        result
);

	// Only slots below the search ceiling can ever be granted, and only the
	// addressable ones need parameters and a pending flag.
	localparam int unsigned SEARCH = (SLOTS < MAX_SEARCH) ? SLOTS : MAX_SEARCH;
	localparam int unsigned NSTORE = (SLOTS < HANDLE_MAX) ? SLOTS : HANDLE_MAX;

	logic [SEARCH-1:0]  used_q;
	logic [NSTORE-1:0]  pend_q;
	logic signed [31:0] a_q [NSTORE];
	logic signed [31:0] b_q [NSTORE];
	logic signed [31:0] c_q [NSTORE];
	logic [3:0]         count_q;

	hsp_search_t        srch;
	logic               handle_ok;
	logic               op_known;
	logic               sel_used;
	logic               sel_pend;
	logic               alloc_pend;
	logic signed [31:0] sel_a;
	logic signed [31:0] sel_b;
	logic signed [31:0] sel_c;
	logic               alloc_go;
	logic               free_go;
	logic               set_go;
	logic               commit_go;
	logic [3:0]         count_d;

	hsp_first_free #(.SEARCH(SEARCH)) u_first_free (
		.used   (used_q),
		.limit  (max_handles),
		.search (srch)
	);

	always_comb begin
		handle_ok  = (int'(item.handle) < int'(SLOTS));
		op_known   = (item.op <= OP_COMMIT);
		sel_used   = 1'b0;
		sel_pend   = 1'b0;
		alloc_pend = 1'b0;
		sel_a      = '0;
		sel_b      = '0;
		sel_c      = '0;
		for (int i = 0; i < int'(SEARCH); i++) begin
			if ({1'b0, item.handle} == MH_W'(i)) begin
				sel_used = used_q[i];
			end
		end
		for (int i = 0; i < int'(NSTORE); i++) begin
			if (item.handle == HANDLE_W'(i)) begin
				sel_pend = pend_q[i];
				sel_a    = a_q[i];
				sel_b    = b_q[i];
				sel_c    = c_q[i];
			end
			if (srch.index == MH_W'(i)) begin
				alloc_pend = pend_q[i];
			end
		end

		alloc_go  = fire && (item.op == OP_ALLOC) && srch.found;
		free_go   = fire && handle_ok && (item.op == OP_FREE) && sel_used;
		set_go    = fire && handle_ok && (item.op == OP_SET);
		commit_go = fire && handle_ok && (item.op == OP_COMMIT);

		count_d = count_q;
		if (alloc_go) begin
			count_d = count_q + 4'd1;
		end else if (free_go && (count_q != 4'd0)) begin
			count_d = count_q - 4'd1;
		end

		result            = '0;
		result.status     = ST_OK;
		result.slot       = item.handle;
		result.used_count = count_d;
		if (item.op == OP_ALLOC) begin
			if (srch.found) begin
				result.slot    = srch.index[HANDLE_W-1:0];
				result.pending = alloc_pend;
			end else begin
				result.status = ST_NONE_FREE;
				result.slot   = '0;
			end
		end else if (!op_known || !handle_ok) begin
			result.status = ST_BAD_SLOT;
		end else begin
			result.pending = sel_pend;
			case (item.op)
				OP_FREE: begin
					if (!sel_used) begin
						result.status = ST_BAD_SLOT;
					end
				end
				OP_GET, OP_COMMIT: begin
					result.out_a = sel_a;
					result.out_b = sel_b;
					result.out_c = sel_c;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			pend_q  <= '0;
			count_q <= '0;
			for (int i = 0; i < int'(NSTORE); i++) begin
				a_q[i] <= '0;
				b_q[i] <= '0;
				c_q[i] <= '0;
			end
		end else begin
			count_q <= count_d;
			for (int i = 0; i < int'(SEARCH); i++) begin
				if (alloc_go && (srch.index == MH_W'(i))) begin
					used_q[i] <= 1'b1;
				end else if (free_go && ({1'b0, item.handle} == MH_W'(i))) begin
					used_q[i] <= 1'b0;
				end
			end
			for (int i = 0; i < int'(NSTORE); i++) begin
				if (alloc_go && (srch.index == MH_W'(i))) begin
					pend_q[i] <= 1'b1;
					a_q[i]    <= DEFAULT_A;
					b_q[i]    <= DEFAULT_B;
					c_q[i]    <= DEFAULT_C;
				end else if (set_go && (item.handle == HANDLE_W'(i))) begin
					pend_q[i] <= 1'b1;
					a_q[i]    <= item.value_a;
					b_q[i]    <= item.value_b;
					c_q[i]    <= item.value_c;
				end else if (commit_go && (item.handle == HANDLE_W'(i))) begin
					pend_q[i] <= 1'b0;
				end
			end
		end
	end

	`HSP_ASSERT_ALWAYS(a_count_matches_used, $countones(used_q) == int'(count_q), "count out of step with used slots")
	`HSP_ASSERT_NEXT(a_alloc_raises_count, alloc_go, count_q == 4'($past(count_q) + 4'd1), "allocate did not raise count")

endmodule

// ===== rtl/handle_slot_pool.sv =====
// Top level of the handle slot pool: input stage, result stage and configuration register.
// Depends on hsp_pkg, hsp_core and handle_slot_pool_assert.svh.
`include "handle_slot_pool_assert.svh"

// The handle slot pool manages SLOTS handles, each with three signed 32-bit
// parameters and a pending-change flag. Every transfer on the input channel is
// one operation (allocate, free, set, get or commit) and yields exactly one
// result transfer, in order. An operation is captured in the input stage, is
// carried out on the slot state by combinational logic as it moves into the
// result stage, and is presented on the output from the result stage register.
// One operation is taken every cycle while the output side is not stalling;
// the first-free priority encoder and the slot update are combinational, and
// the slot state is registered as each operation moves on, so each operation
// sees all the changes of the one before it. When the result stage holds an
// untaken result, the input stage keeps its operation and stall is raised on
// the input side. The max_handles register (reset 8) limits allocate to the
// lowest slots; write it only while no operation is in flight. Slots past the
// addressable handle range can be granted when SLOTS and max_handles allow it,
// but cannot be freed afterwards.
module handle_slot_pool import hsp_pkg::*; #(
	parameter int unsigned SLOTS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  hsp_in_t         in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output hsp_out_t        out_data,
	input  logic            cfg_wr_en,
	input  logic [MH_W-1:0] cfg_wr_data
);

	logic            valid_s1;
	hsp_in_t         item_s1;
	logic            valid_s2;
	hsp_out_t        data_s2;
	logic [MH_W-1:0] max_handles_q;
	logic            adv;
	logic            fire;
	hsp_out_t        result;

	// The result stage can take a new result when it is empty or being drained.
	assign adv      = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_handles_q <= MAX_HANDLES_RESET;
		end else if (cfg_wr_en) begin
			max_handles_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload stages carry no reset; their valid bits qualify them.
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
		if (fire) begin
			data_s2 <= result;
		end
	end

	hsp_core #(.SLOTS(SLOTS)) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.max_handles (max_handles_q),
		.result      (result)
	);

	`HSP_ASSERT_IMPL(a_stall_needs_item, in_stall, valid_s1, "input stalled with an empty input stage")
	`HSP_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv, valid_s1 && (item_s1 == $past(item_s1)), "held operation changed")

endmodule

// ===== tb/handle_slot_pool_tb.sv =====
// Self-checking testbench for handle_slot_pool: directed and random slot operations
// against an in-bench predictor of the pool, with random idling on both channels.
// Depends on hsp_pkg and the handle_slot_pool RTL.
module handle_slot_pool_tb import hsp_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	// The pool size of the instance below (the RTL default).
	localparam int unsigned POOL_SLOTS = 8;
	// Operation codes past commit; the block rejects these.
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_MID   = 3'd6;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	// Cycles with no transfer on either channel before the run is abandoned. The
	// longest correct quiet stretch is the deliberate receiver hold-off below.
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 250;
	// Settling time after a drain, enough for the input and result stages to empty.
	localparam int SETTLE_CYCLES = 6;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	hsp_in_t         in_data = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	hsp_out_t        out_data;
	logic            cfg_wr_en = 1'b0;
	logic [MH_W-1:0] cfg_wr_data = '0;

	handle_slot_pool dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the pool. It is advanced once per accepted input transfer,
	// so it always reflects every operation that the block has taken so far.
	logic                slot_taken [POOL_SLOTS] = '{default: 1'b0};
	logic                slot_dirty [POOL_SLOTS] = '{default: 1'b0};
	logic signed [31:0]  store_a [POOL_SLOTS] = '{default: '0};
	logic signed [31:0]  store_b [POOL_SLOTS] = '{default: '0};
	logic signed [31:0]  store_c [POOL_SLOTS] = '{default: '0};
	logic [3:0]          taken_count = '0;
	logic [MH_W-1:0]     alloc_limit = MAX_HANDLES_RESET;

	// Results predicted for accepted operations, oldest first.
	hsp_out_t predicted_results[$];

	int n_sent = 0;
	int n_checked = 0;
	int mismatches = 0;
	int pool_full_hits = 0;
	int settings_used = 0;
	int op_seen [8] = '{default: 0};
	int burst_left = 0;
	int quiet_cycles = 0;
	bit hold_request = 1'b0;

	// Applies one operation to the shadow pool and returns the result it must give.
	function automatic hsp_out_t pool_apply(hsp_in_t req);
		hsp_out_t    rsp;
		int unsigned search;
		int          pick;
		rsp = '0;
		rsp.status = ST_OK;
		rsp.slot = req.handle;
		if (req.op == OP_ALLOC) begin
			// A limit above the pool size only searches the slots that exist.
			search = (alloc_limit < POOL_SLOTS) ? alloc_limit : POOL_SLOTS;
			pick = -1;
			for (int i = 0; i < search; i++) begin
				if (pick < 0 && !slot_taken[i])
					pick = i;
			end
			if (pick >= 0) begin
				rsp.slot = pick[2:0];
				rsp.pending = slot_dirty[pick];
				store_a[pick] = DEFAULT_A;
				store_b[pick] = DEFAULT_B;
				store_c[pick] = DEFAULT_C;
				slot_dirty[pick] = 1'b1;
				slot_taken[pick] = 1'b1;
				taken_count = taken_count + 4'd1;
			end else begin
				rsp.status = ST_NONE_FREE;
				rsp.slot = '0;
				pool_full_hits++;
			end
		end else if (req.op > OP_COMMIT || req.handle >= POOL_SLOTS) begin
			rsp.status = ST_BAD_SLOT;
		end else begin
			rsp.pending = slot_dirty[req.handle];
			case (req.op)
				OP_FREE: begin
					// Freeing a slot that is not in use is refused and leaves the count alone.
					if (slot_taken[req.handle]) begin
						slot_taken[req.handle] = 1'b0;
						if (taken_count > 0)
							taken_count = taken_count - 4'd1;
					end else begin
						rsp.status = ST_BAD_SLOT;
					end
				end
				OP_SET: begin
					store_a[req.handle] = req.value_a;
					store_b[req.handle] = req.value_b;
					store_c[req.handle] = req.value_c;
					slot_dirty[req.handle] = 1'b1;
				end
				default: begin
					// Get and commit both read the slot, used or not.
					rsp.out_a = store_a[req.handle];
					rsp.out_b = store_b[req.handle];
					rsp.out_c = store_c[req.handle];
					if (req.op == OP_COMMIT)
						slot_dirty[req.handle] = 1'b0;
				end
			endcase
		end
		rsp.used_count = taken_count;
		return rsp;
	endfunction

	function automatic hsp_in_t make_op(logic [2:0] op, logic [2:0] handle,
			logic signed [31:0] a = '0, logic signed [31:0] b = '0,
			logic signed [31:0] c = '0);
		hsp_in_t req;
		req.op = op;
		req.handle = handle;
		req.value_a = a;
		req.value_b = b;
		req.value_c = c;
		return req;
	endfunction

	// Parameter values lean on the signed extremes and on all-zero and all-one words.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh0000_0000;
			3: return 32'shFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Most operations aim at a slot that is in use, so that set, get, commit
	// and free mostly act on live handles; the rest go anywhere.
	function automatic logic [2:0] pick_handle();
		logic [2:0] live[$];
		for (int i = 0; i < POOL_SLOTS; i++) begin
			if (slot_taken[i])
				live.push_back(i[2:0]);
		end
		if (live.size() > 0 && $urandom_range(0, 9) < 7)
			return live[$urandom_range(0, live.size() - 1)];
		return 3'($urandom_range(0, 7));
	endfunction

	// Offers one operation and holds it until the block takes it. The sender
	// works in bursts; between bursts it drops valid for a random gap.
	task automatic send_op(hsp_in_t req);
		int gap;
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 20);
		end
	endtask

	// Stops offering and waits until every result of the operations sent so far
	// has been taken.
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		while (n_checked < n_sent)
			@(posedge clk);
	endtask

	// The register may only change with nothing in flight, so the pool is
	// drained first and given the pipeline's latency to settle.
	task automatic set_max_handles(logic [MH_W-1:0] limit);
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= limit;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		alloc_limit = limit;
		settings_used++;
	endtask

	task automatic run_random_ops(int count);
		int         r;
		logic [2:0] op;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 28)
				op = OP_ALLOC;
			else if (r < 45)
				op = OP_FREE;
			else if (r < 62)
				op = OP_SET;
			else if (r < 76)
				op = OP_GET;
			else if (r < 92)
				op = OP_COMMIT;
			else
				op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
			send_op(make_op(op, pick_handle(), pick_value(), pick_value(), pick_value()));
		end
	endtask

	// Straight after reset every slot is free, clean and zero. Get and commit
	// still read an unused slot, free refuses it, and set writes it anyway.
	task automatic test_unused_slots();
		send_op(make_op(OP_GET, 3'd0));
		send_op(make_op(OP_COMMIT, 3'd7));
		send_op(make_op(OP_FREE, 3'd5));
		send_op(make_op(OP_SET, 3'd2, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF));
		send_op(make_op(OP_GET, 3'd2));
	endtask

	// Allocates until the pool is full, then once more, and checks that a freed
	// slot in the middle is the next one granted. Slot 2 is still pending from
	// the set above, so its grant reports pending.
	task automatic test_fill_and_exhaust();
		repeat (POOL_SLOTS + 1) send_op(make_op(OP_ALLOC, 3'd7));
		send_op(make_op(OP_FREE, 3'd3));
		send_op(make_op(OP_FREE, 3'd3));
		send_op(make_op(OP_ALLOC, 3'd0));
	endtask

	// A set, then get, commit and get again to see pending clear; then the
	// undefined operation codes, which must be refused without side effects.
	task automatic test_set_get_commit();
		send_op(make_op(OP_SET, 3'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000));
		send_op(make_op(OP_GET, 3'd0));
		send_op(make_op(OP_COMMIT, 3'd0));
		send_op(make_op(OP_GET, 3'd0));
		send_op(make_op(OP_SPARE_FIRST, 3'd1, pick_value(), pick_value(), pick_value()));
		send_op(make_op(OP_SPARE_MID, 3'd4, pick_value(), pick_value(), pick_value()));
		send_op(make_op(OP_SPARE_LAST, 3'd6, pick_value(), pick_value(), pick_value()));
	endtask

	// Random traffic under several search limits: the reset value, zero (every
	// allocate fails), one, a small window, the largest code (clipped to the
	// pool) and back to the reset value.
	task automatic test_search_limit();
		logic [MH_W-1:0] limits [6];
		limits = '{MAX_HANDLES_RESET, 4'd0, 4'd1, 4'd3, 4'd15, MAX_HANDLES_RESET};
		for (int k = 0; k < 6; k++) begin
			set_max_handles(limits[k]);
			run_random_ops(220);
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering,
	// so the block fills and must stall its input until the receiver resumes.
	task automatic test_backpressure();
		hold_request = 1'b1;
		run_random_ops(60);
		pause_until_drained();
	endtask

	// Short stretches of traffic separated by full drains of the pool.
	task automatic test_drain_pause();
		for (int k = 0; k < 5; k++) begin
			run_random_ops(40);
			pause_until_drained();
		end
	endtask

	// Receiver: stalls on a pattern of its own, switching between segments of
	// no stall, light and heavy random stall and alternate cycles. On request it
	// holds off for a long stretch set by HOLD_CYCLES. Each assignment is followed by a
	// clock edge, so out_stall changes at most once per edge.
	initial begin : receiver
		int mode;
		int seg_len;
		forever begin
			if (hold_request) begin
				for (int n = 0; n < HOLD_CYCLES; n++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
				hold_request = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				seg_len = $urandom_range(10, 120);
				for (int n = 0; n < seg_len && !hold_request; n++) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= ($urandom_range(0, 3) != 0);
						default: out_stall <= n[0];
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Every accepted input transfer advances the shadow pool and queues the
	// result that the block owes for it.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			op_seen[in_data.op]++;
			predicted_results.push_back(pool_apply(in_data));
		end
	end

	task automatic check_field(string field, int idx, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %h, got %h", idx, field, want, got);
		end
	endtask

	// Every accepted result transfer is matched against the oldest prediction.
	always @(posedge clk) begin : result_check
		hsp_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with none outstanding: %p", n_checked, out_data);
			end else begin
				want = predicted_results.pop_front();
				check_field("status", n_checked, 32'(want.status), 32'(out_data.status));
				check_field("slot", n_checked, 32'(want.slot), 32'(out_data.slot));
				check_field("out_a", n_checked, want.out_a, out_data.out_a);
				check_field("out_b", n_checked, want.out_b, out_data.out_b);
				check_field("out_c", n_checked, want.out_c, out_data.out_c);
				check_field("pending", n_checked, 32'(want.pending), 32'(out_data.pending));
				check_field("used_count", n_checked, 32'(want.used_count),
					32'(out_data.used_count));
			end
			n_checked++;
		end
	end

	// Ends the run when neither channel has moved a transfer for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no transfer for %0d cycles, %0d of %0d results seen",
					quiet_cycles, n_checked, n_sent);
				$display("handle_slot_pool test failed");
				$finish;
			end
		end
	end

	initial begin : sequencer
		int leftover;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unused_slots();
		test_fill_and_exhaust();
		test_set_get_commit();
		test_search_limit();
		test_backpressure();
		test_drain_pause();

		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		leftover = predicted_results.size();
		if (leftover > 0)
			$display("%0d predicted results never arrived", leftover);

		$display("Ran %0d operations: %0d allocate, %0d free, %0d set, %0d get, %0d commit,",
			n_sent, op_seen[OP_ALLOC], op_seen[OP_FREE], op_seen[OP_SET],
			op_seen[OP_GET], op_seen[OP_COMMIT]);
		$display("%0d undefined; %0d search limits, %0d allocations refused, %0d mismatches.",
			op_seen[OP_SPARE_FIRST] + op_seen[OP_SPARE_MID] + op_seen[OP_SPARE_LAST],
			settings_used, pool_full_hits, mismatches);
		if (mismatches == 0 && leftover == 0)
			$display("handle_slot_pool test passed");
		else
			$display("handle_slot_pool test failed");
		$finish;
	end

endmodule
